[hw/rtl/binary_trie_max_xor_engine_assert.svh]
// Assertion macros shared by the maximum-XOR trie engine RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk, gated by rst.
`ifndef BINARY_TRIE_MAX_XOR_ENGINE_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ENGINE_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define BTMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define BTMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/btmx_pkg.sv]
// Shared types and codes for the maximum-XOR trie engine.
// No dependencies.
package btmx_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  // Action codes carried in the input tuser; bit 1 set means clear.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam int                  ACT_CLEAR_BIT = 1;

  // Result status codes carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_ANSWERED = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_CLEARED  = 3'd4
  } status_t;

endpackage

[hw/rtl/btmx_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module btmx_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/binary_trie_max_xor_engine.sv]
// Maximum-XOR binary trie engine. An item is an insert, a query or a clear; each item
// gives exactly one result item. The trie walks one level per cycle, each level being one
// read of the child memories, and a query then hands over its result (a query on an empty
// trie and a clear go straight to the hand-over). An insert walks the levels that already
// exist and then allocates one new node a cycle for the rest; a new key passes through a
// pool check state before the allocation and then the hand-over state, while a key already
// stored or a rejected insert goes on to the hand-over. Items are processed one at a time;
// a finished result waits in the output register while the next item is taken. No clearing
// pass is needed after reset.
// Depends on btmx_pkg, btmx_ram and binary_trie_max_xor_engine_assert.svh.
`include "binary_trie_max_xor_engine_assert.svh"

module binary_trie_max_xor_engine #(
  parameter int KEY_BITS      = 32,
  parameter int NODE_CAPACITY = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input item stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [btmx_pkg::DATA_W-1:0]    s_axis_tdata,  // [31:0] value
  input  logic [btmx_pkg::ACTION_W-1:0]  s_axis_tuser,  // [1:0] action
  // Result item stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [btmx_pkg::DATA_W-1:0]    m_axis_tdata,  // [31:0] max_xor
  output logic [btmx_pkg::STATUS_W-1:0]  m_axis_tuser   // [2:0] status
);

  import btmx_pkg::*;

  localparam int NODE_W = $clog2(NODE_CAPACITY);
  localparam int FREE_W = $clog2(NODE_CAPACITY + 1);
  localparam int SUM_W  = FREE_W + 1;
  localparam int CNT_W  = $clog2(KEY_BITS + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_INS,
    S_WALK_Q,
    S_CHECK,
    S_ALLOC,
    S_DONE
  } state_t;

  state_t              state;
  logic [KEY_BITS-1:0] key;
  logic [NODE_W-1:0]   node;
  logic [CNT_W-1:0]    cnt;
  logic [KEY_BITS-1:0] acc;
  logic [NODE_W-1:0]   parent;
  logic                parent_root;
  logic                parent_bit;
  logic [DATA_W-1:0]   res_xor;
  status_t             res_status;
  logic [FREE_W-1:0]   next_free;
  logic [NODE_W-1:0]   root_zero;
  logic [NODE_W-1:0]   root_one;
  logic                nonempty;

  // Memory ports.
  logic [NODE_W-1:0] raddr;
  logic [NODE_W-1:0] rd_zero;
  logic [NODE_W-1:0] rd_one;
  logic              zero_we;
  logic              one_we;
  logic [NODE_W-1:0] waddr;
  logic [NODE_W-1:0] zero_wdata;
  logic [NODE_W-1:0] one_wdata;

  btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_zero_ram (
    .clk   (clk),
    .we    (zero_we),
    .waddr (waddr),
    .wdata (zero_wdata),
    .raddr (raddr),
    .rdata (rd_zero)
  );

  btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_one_ram (
    .clk   (clk),
    .we    (one_we),
    .waddr (waddr),
    .wdata (one_wdata),
    .raddr (raddr),
    .rdata (rd_one)
  );

  // Decode of the incoming item and the root level.
  logic [KEY_BITS-1:0] in_key;
  logic                in_bit;
  logic                in_clear;
  logic                in_query;
  logic [NODE_W-1:0]   root_same;
  logic [NODE_W-1:0]   root_other;
  logic                accept;

  assign in_key     = s_axis_tdata[KEY_BITS-1:0];
  assign in_bit     = in_key[KEY_BITS-1];
  assign in_clear   = s_axis_tuser[ACT_CLEAR_BIT];
  assign in_query   = (s_axis_tuser == ACT_QUERY);
  assign root_same  = in_bit ? root_one : root_zero;
  assign root_other = in_bit ? root_zero : root_one;
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Per-level walk terms from the memory read data.
  logic [LVL_W-1:0]    lvl_idx;
  logic                wbit;
  logic [NODE_W-1:0]   same_child;
  logic [NODE_W-1:0]   other_child;
  logic [KEY_BITS-1:0] q_acc;

  assign lvl_idx     = cnt[LVL_W-1:0];
  assign wbit        = key[lvl_idx];
  assign same_child  = wbit ? rd_one : rd_zero;
  assign other_child = wbit ? rd_zero : rd_one;

  always_comb begin
    q_acc = acc;
    if (other_child != '0) begin
      q_acc[lvl_idx] = 1'b1;
    end
  end

  // Pool check and new node contents.
  logic [NODE_W-1:0] nf_idx;
  logic [NODE_W-1:0] nf_succ;
  logic              fits;
  logic [CNT_W-1:0]  alloc_lvl;
  logic              alloc_bit;

  assign nf_idx    = next_free[NODE_W-1:0];
  assign nf_succ   = nf_idx + NODE_W'(1);
  assign fits      = (SUM_W'(next_free) + SUM_W'(cnt)) <= SUM_W'(NODE_CAPACITY);
  assign alloc_lvl = cnt - CNT_W'(2);
  assign alloc_bit = key[alloc_lvl[LVL_W-1:0]];

  // Read address follows the child chosen at this level so the walk takes one level a cycle.
  always_comb begin
    case (state)
      S_IDLE:     raddr = (in_query && root_other != '0) ? root_other : root_same;
      S_WALK_INS: raddr = same_child;
      S_WALK_Q:   raddr = (other_child != '0) ? other_child : same_child;
      default:    raddr = node;
    endcase
  end

  // Writes: the parent link in the check cycle, then one new node per allocation cycle.
  always_comb begin
    zero_we    = 1'b0;
    one_we     = 1'b0;
    waddr      = nf_idx;
    zero_wdata = '0;
    one_wdata  = '0;
    case (state)
      S_CHECK: begin
        waddr      = parent;
        zero_wdata = nf_idx;
        one_wdata  = nf_idx;
        zero_we    = fits && !parent_root && !parent_bit;
        one_we     = fits && !parent_root && parent_bit;
      end
      S_ALLOC: begin
        zero_we = 1'b1;
        one_we  = 1'b1;
        if (cnt > CNT_W'(1)) begin
          zero_wdata = alloc_bit ? '0 : nf_succ;
          one_wdata  = alloc_bit ? nf_succ : '0;
        end
      end
      default: begin
        zero_we = 1'b0;
      end
    endcase
  end

  // Sequencer, trie root state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_free     <= FREE_W'(1);
      root_zero     <= '0;
      root_one      <= '0;
      nonempty      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The hand-over state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key     <= in_key;
            res_xor <= '0;
            if (in_clear) begin
              next_free  <= FREE_W'(1);
              root_zero  <= '0;
              root_one   <= '0;
              nonempty   <= 1'b0;
              res_status <= STAT_CLEARED;
              state      <= S_DONE;
            end else if (in_query) begin
              acc <= (root_other != '0) ? (KEY_BITS'(1) << (KEY_BITS - 1)) : '0;
              if (!nonempty) begin
                res_status <= STAT_EMPTY;
                state      <= S_DONE;
              end else if (KEY_BITS == 1 || (root_other == '0 && root_same == '0)) begin
                res_xor    <= DATA_W'((root_other != '0) ? (KEY_BITS'(1) << (KEY_BITS - 1))
                                                         : KEY_BITS'(0));
                res_status <= STAT_ANSWERED;
                state      <= S_DONE;
              end else begin
                node  <= (root_other != '0) ? root_other : root_same;
                cnt   <= CNT_W'(KEY_BITS - 2);
                state <= S_WALK_Q;
              end
            end else begin
              if (root_same == '0) begin
                cnt         <= CNT_W'(KEY_BITS);
                parent_root <= 1'b1;
                parent_bit  <= in_bit;
                state       <= S_CHECK;
              end else if (KEY_BITS == 1) begin
                res_status <= STAT_INSERTED;
                state      <= S_DONE;
              end else begin
                node  <= root_same;
                cnt   <= CNT_W'(KEY_BITS - 2);
                state <= S_WALK_INS;
              end
            end
          end
        end
        S_WALK_INS: begin
          if (same_child == '0) begin
            cnt         <= cnt + CNT_W'(1);
            parent      <= node;
            parent_root <= 1'b0;
            parent_bit  <= wbit;
            state       <= S_CHECK;
          end else if (cnt == '0) begin
            res_status <= STAT_INSERTED;
            state      <= S_DONE;
          end else begin
            node <= same_child;
            cnt  <= cnt - CNT_W'(1);
          end
        end
        S_WALK_Q: begin
          acc <= q_acc;
          if ((other_child == '0 && same_child == '0) || cnt == '0) begin
            res_xor    <= DATA_W'(q_acc);
            res_status <= STAT_ANSWERED;
            state      <= S_DONE;
          end else begin
            node <= (other_child != '0) ? other_child : same_child;
            cnt  <= cnt - CNT_W'(1);
          end
        end
        S_CHECK: begin
          if (!fits) begin
            res_status <= STAT_REJECTED;
            state      <= S_DONE;
          end else begin
            if (parent_root) begin
              if (parent_bit) begin
                root_one <= nf_idx;
              end else begin
                root_zero <= nf_idx;
              end
            end
            nonempty <= 1'b1;
            state    <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          next_free <= next_free + FREE_W'(1);
          cnt       <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            res_status <= STAT_INSERTED;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_xor;
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The pool counter never runs past the capacity.
  `BTMX_ASSERT_NOW(a_pool_bound, 1'b1, next_free <= FREE_W'(NODE_CAPACITY), "pool overrun")
  // Memories are only written while linking or allocating.
  `BTMX_ASSERT_NOW(a_write_window, zero_we || one_we, state == S_CHECK || state == S_ALLOC,
                   "child store written outside an insert")
  // Each allocation cycle takes exactly one node.
  `BTMX_ASSERT_NEXT(a_alloc_step, state == S_ALLOC, next_free == $past(next_free) + FREE_W'(1),
                    "allocation did not advance the free pointer")
  // An empty trie has no root children.
  `BTMX_ASSERT_NOW(a_empty_root, !nonempty, root_zero == '0 && root_one == '0,
                   "root child present in an empty trie")

endmodule
